>>> rtl/core/mehr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mehr_pkg;

    // Width of the read limit field, fixed by the interface.
    localparam int LIMIT_W = 7;
    localparam int TIME_W = 48;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_BUTTON = 2'd0,
        OP_MOVE   = 2'd1,
        OP_WHEEL  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    // One mouse record as held in a cell.
    typedef struct packed {
        logic [7:0]          buttons;
        logic signed [15:0]  x_axis;
        logic signed [15:0]  y_axis;
        logic signed [15:0]  wheel;
        logic signed [15:0]  tilt;
        logic [TIME_W-1:0]   time_res;
    } rec_t;

    // Per-cell control: shift toward the head, or load the new record.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    // Controller commands to the cell chain and result stage.
    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic fallback;
        logic last;
    } ring_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/mehr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One storage cell of the record chain. The head of the chain holds the
// oldest record; a shift moves every record one place toward the head.
module mehr_cell (
    input  wire                logic clk,
    input  wire mehr_pkg::cell_ctl_t ctl,
    input  wire mehr_pkg::rec_t      neighbor,
    input  wire mehr_pkg::rec_t      fresh,
    output      mehr_pkg::rec_t      rec
);

    mehr_pkg::rec_t rec_reg;
    mehr_pkg::rec_t rec_next;

    // A load of a new record wins over taking the neighbor's record.
    always_comb
    begin
        priority if (ctl.load)
        begin
            rec_next = fresh;
        end
        else if (ctl.shift)
        begin
            rec_next = neighbor;
        end
        else
        begin
            rec_next = rec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

`default_nettype wire

>>> rtl/core/mehr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer for the record ring: tracks the fill level, the held button
// state and the connected flag, and walks a read through the chain.
module mehr_ctrl #(
    parameter int RING_DEPTH = 64,
    parameter int CNT_W = 7
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic [1:0]                    operation,
    input  wire logic [7:0]                    button_mask,
    input  wire logic                          pressed,
    input  wire logic [mehr_pkg::LIMIT_W-1:0]  read_limit,
    input  wire logic                          connected_we,
    input  wire logic                          connected_wdata,
    output      mehr_pkg::ring_cmd_t           cmd,
    output      logic [CNT_W-1:0]              fill,
    output      logic [7:0]                    held_buttons,
    output      logic [7:0]                    new_buttons
);

    mehr_pkg::state_t state_reg;
    mehr_pkg::state_t state_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] left_next;
    logic [7:0]       held_buttons_reg;
    logic [7:0]       held_buttons_next;
    logic             connected_reg;

    logic                         accept;
    logic                         is_read;
    logic                         read_go;
    logic                         full;
    logic [mehr_pkg::LIMIT_W-1:0] fill_ext;
    logic [CNT_W-1:0]             take;

    assign accept   = start && (state_reg == mehr_pkg::ST_IDLE);
    assign is_read  = (mehr_pkg::op_t'(operation) == mehr_pkg::OP_READ);
    assign read_go  = accept && is_read && (read_limit != '0);
    assign full     = (fill_reg == CNT_W'(RING_DEPTH));
    assign fill_ext = mehr_pkg::LIMIT_W'(fill_reg);
    assign take     = (fill_ext < read_limit) ? fill_reg : CNT_W'(read_limit);

    // Button state that an event would leave behind.
    always_comb
    begin
        unique case (mehr_pkg::op_t'(operation))
            mehr_pkg::OP_BUTTON:
            begin
                new_buttons = pressed ? (held_buttons_reg | button_mask)
                                      : (held_buttons_reg & ~button_mask);
            end
            mehr_pkg::OP_MOVE, mehr_pkg::OP_WHEEL, mehr_pkg::OP_READ:
            begin
                new_buttons = held_buttons_reg;
            end
            default:
            begin
                new_buttons = held_buttons_reg;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mehr_pkg::ST_IDLE:
            begin
                if (read_go && (fill_reg != '0))
                begin
                    state_next = mehr_pkg::ST_DRAIN;
                end
            end
            mehr_pkg::ST_DRAIN:
            begin
                if (left_reg == CNT_W'(1))
                begin
                    state_next = mehr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mehr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        cmd.push     = 1'b0;
        cmd.pop      = 1'b0;
        cmd.full     = full;
        cmd.fallback = 1'b0;
        cmd.last     = 1'b0;
        busy         = 1'b0;
        unique case (state_reg)
            mehr_pkg::ST_IDLE:
            begin
                cmd.push     = accept && !is_read && connected_reg;
                cmd.fallback = read_go && (fill_reg == '0);
            end
            mehr_pkg::ST_DRAIN:
            begin
                busy     = 1'b1;
                cmd.pop  = 1'b1;
                cmd.last = (left_reg == CNT_W'(1));
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Fill level, records left in the current read, and held buttons.
    always_comb
    begin
        fill_next         = fill_reg;
        left_next         = left_reg;
        held_buttons_next = held_buttons_reg;
        if (cmd.push)
        begin
            held_buttons_next = new_buttons;
            if (!full)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        if (cmd.pop)
        begin
            fill_next = fill_reg - CNT_W'(1);
            left_next = left_reg - CNT_W'(1);
        end
        else if (read_go)
        begin
            left_next = take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mehr_pkg::ST_IDLE;
            fill_reg         <= '0;
            left_reg         <= '0;
            held_buttons_reg <= '0;
            connected_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            left_reg         <= left_next;
            held_buttons_reg <= held_buttons_next;
            if (connected_we)
            begin
                connected_reg <= connected_wdata;
            end
        end
    end

    assign fill         = fill_reg;
    assign held_buttons = held_buttons_reg;

    // The fill level never passes the ring depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(RING_DEPTH))
        else $error("fill level above ring depth");

    // While draining, the records left are non-zero and all held.
    a_left_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mehr_pkg::ST_DRAIN) |-> (left_reg != '0) && (left_reg <= fill_reg))
        else $error("drain count out of range");

    // Each pop removes exactly one record.
    a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (fill_reg == $past(fill_reg) - CNT_W'(1)))
        else $error("pop did not drop fill level by one");

    // Pushing into a full ring overwrites and keeps the fill level.
    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && full) |=> (fill_reg == CNT_W'(RING_DEPTH)))
        else $error("fill level changed on overwrite");

endmodule

`default_nettype wire

>>> rtl/core/mouse_event_history_ring.sv
`timescale 1ns / 1ps
`default_nettype none

// Event items leave busy low, so the next item may follow at once. A read of n held
// records raises busy while it drains, one record per cycle leaving the head cell of the
// chain; the read is registered into the drain state, then each record into the result
// register. A read of an empty ring gives its single fallback record in the cycle after
// acceptance. The receiver cannot stall: each result is valid for exactly one cycle.
// Reset clears the fill level, held buttons and connected flag; record cells keep contents.
module mouse_event_history_ring #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic                          connected_we,
    input  wire logic                          connected_wdata,
    input  wire logic [1:0]                    operation,
    input  wire logic [7:0]                    button_mask,
    input  wire logic                          pressed,
    input  wire logic signed [15:0]            x_value,
    input  wire logic signed [15:0]            y_value,
    input  wire logic [mehr_pkg::TIME_W-1:0]   timestamp,
    input  wire logic [mehr_pkg::LIMIT_W-1:0]  read_limit,
    output      logic                          result_valid,
    output      logic [7:0]                    buttons,
    output      logic signed [15:0]            x_axis,
    output      logic signed [15:0]            y_axis,
    output      logic signed [15:0]            wheel,
    output      logic signed [15:0]            tilt,
    output      logic [mehr_pkg::TIME_W-1:0]   time_res,
    output      logic                          from_last_state,
    output      logic                          is_last
);

    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    mehr_pkg::ring_cmd_t cmd;
    logic [CNT_W-1:0]    fill;
    logic [7:0]          held_buttons;
    logic [7:0]          new_buttons;
    mehr_pkg::rec_t      fresh;
    mehr_pkg::rec_t      chain [RING_DEPTH];

    mehr_pkg::rec_t rec_out_reg;
    mehr_pkg::rec_t rec_out_next;
    logic           valid_reg;
    logic           from_last_reg;
    logic           last_reg;

    mehr_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .button_mask     (button_mask),
        .pressed         (pressed),
        .read_limit      (read_limit),
        .connected_we    (connected_we),
        .connected_wdata (connected_wdata),
        .cmd             (cmd),
        .fill            (fill),
        .held_buttons    (held_buttons),
        .new_buttons     (new_buttons)
    );

    // New record built from the held buttons and the event payload.
    always_comb
    begin
        fresh.buttons  = new_buttons;
        fresh.x_axis   = '0;
        fresh.y_axis   = '0;
        fresh.wheel    = '0;
        fresh.tilt     = '0;
        fresh.time_res = timestamp;
        unique case (mehr_pkg::op_t'(operation))
            mehr_pkg::OP_MOVE:
            begin
                fresh.x_axis = x_value;
                fresh.y_axis = y_value;
            end
            mehr_pkg::OP_WHEEL:
            begin
                fresh.wheel = y_value;
                fresh.tilt  = x_value;
            end
            mehr_pkg::OP_BUTTON, mehr_pkg::OP_READ:
            begin
                fresh.x_axis = '0;
            end
            default:
            begin
                fresh.x_axis = '0;
            end
        endcase
    end

    // Chain of cells: the head holds the oldest record. A push fills the
    // first free cell, or shifts and fills the tail cell when the ring is full.
    for (genvar i = 0; i < RING_DEPTH; i++)
    begin : g_cell
        mehr_pkg::cell_ctl_t ctl;
        mehr_pkg::rec_t      neighbor;

        assign ctl.shift = cmd.pop || (cmd.push && cmd.full);
        assign ctl.load  = cmd.push && (cmd.full ? (i == RING_DEPTH - 1)
                                                 : (fill == CNT_W'(i)));

        if (i < RING_DEPTH - 1)
        begin : g_mid
            assign neighbor = chain[i + 1];
        end
        else
        begin : g_tail
            assign neighbor = chain[i];
        end

        mehr_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .neighbor (neighbor),
            .fresh    (fresh),
            .rec      (chain[i])
        );
    end

    // Result stage: the head record on a pop, or the last state on fallback.
    always_comb
    begin
        rec_out_next = rec_out_reg;
        if (cmd.pop)
        begin
            rec_out_next = chain[0];
        end
        else if (cmd.fallback)
        begin
            rec_out_next         = '0;
            rec_out_next.buttons = held_buttons;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_out_reg <= rec_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            from_last_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            valid_reg     <= cmd.pop || cmd.fallback;
            from_last_reg <= cmd.fallback;
            last_reg      <= cmd.fallback || cmd.last;
        end
    end

    assign result_valid    = valid_reg;
    assign buttons         = rec_out_reg.buttons;
    assign x_axis          = rec_out_reg.x_axis;
    assign y_axis          = rec_out_reg.y_axis;
    assign wheel           = rec_out_reg.wheel;
    assign tilt            = rec_out_reg.tilt;
    assign time_res        = rec_out_reg.time_res;
    assign from_last_state = from_last_reg;
    assign is_last         = last_reg;

endmodule

`default_nettype wire

>>> test/mouse_event_history_ring_tb.sv
`timescale 1ns / 1ps

module mouse_event_history_ring_tb;

    localparam int DEPTH = 64;
    localparam int QUIET_LIMIT = 500;
    localparam longint WATCHDOG_NS = 5_000_000;

    // One input item as presented on the command ports.
    typedef struct {
        mehr_pkg::op_t                     operation;
        logic [7:0]                        button_mask;
        logic                              pressed;
        logic signed [15:0]                x_value;
        logic signed [15:0]                y_value;
        logic [mehr_pkg::TIME_W-1:0]       timestamp;
        logic [mehr_pkg::LIMIT_W-1:0]      read_limit;
    } mouse_item_t;

    // One record that the block owes us, with its read markers.
    typedef struct {
        mehr_pkg::rec_t  rec;
        logic            fallback;
        logic            last;
    } due_record_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic                              connected_we = 1'b0;
    logic                              connected_wdata = 1'b0;
    logic [1:0]                        operation = '0;
    logic [7:0]                        button_mask = '0;
    logic                              pressed = 1'b0;
    logic signed [15:0]                x_value = '0;
    logic signed [15:0]                y_value = '0;
    logic [mehr_pkg::TIME_W-1:0]       timestamp = '0;
    logic [mehr_pkg::LIMIT_W-1:0]      read_limit = '0;
    logic                              result_valid;
    logic [7:0]                        buttons;
    logic signed [15:0]                x_axis;
    logic signed [15:0]                y_axis;
    logic signed [15:0]                wheel;
    logic signed [15:0]                tilt;
    logic [mehr_pkg::TIME_W-1:0]       time_res;
    logic                              from_last_state;
    logic                              is_last;

    // Mirror of the block's history ring and last state.
    mehr_pkg::rec_t  history [DEPTH];
    int              newest_slot_m = 0;
    int              held_m = 0;
    logic [7:0]      last_buttons_m = '0;
    logic            link_up_m = 1'b0;

    mouse_item_t   items_to_send [$];
    due_record_t   records_due [$];
    logic          took = 1'b0;
    int            sender_idle_pct = 0;

    int            fails = 0;
    int            items_taken = 0;
    int            records_checked = 0;
    int            fallback_seen = 0;
    int            slots_overwritten = 0;
    int            longest_read = 0;

    mouse_event_history_ring #(
        .RING_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .connected_we(connected_we),
        .connected_wdata(connected_wdata),
        .operation(operation),
        .button_mask(button_mask),
        .pressed(pressed),
        .x_value(x_value),
        .y_value(y_value),
        .timestamp(timestamp),
        .read_limit(read_limit),
        .result_valid(result_valid),
        .buttons(buttons),
        .x_axis(x_axis),
        .y_axis(y_axis),
        .wheel(wheel),
        .tilt(tilt),
        .time_res(time_res),
        .from_last_state(from_last_state),
        .is_last(is_last)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Update the mirror for one accepted item and queue the records it owes.
    task automatic apply_mouse_item(input mouse_item_t it);
        mehr_pkg::rec_t  fresh;
        due_record_t     owed;
        int              take;
        int              first;
        if (it.operation != mehr_pkg::OP_READ)
        begin
            if (link_up_m)
            begin
                fresh = '0;
                fresh.buttons = last_buttons_m;
                case (it.operation)
                    mehr_pkg::OP_BUTTON:
                    begin
                        if (it.pressed)
                            fresh.buttons = last_buttons_m | it.button_mask;
                        else
                            fresh.buttons = last_buttons_m & ~it.button_mask;
                    end
                    mehr_pkg::OP_MOVE:
                    begin
                        fresh.x_axis = it.x_value;
                        fresh.y_axis = it.y_value;
                    end
                    default:
                    begin
                        fresh.wheel = it.y_value;
                        fresh.tilt = it.x_value;
                    end
                endcase
                fresh.time_res = it.timestamp;
                newest_slot_m = (newest_slot_m + 1) % DEPTH;
                if (held_m == DEPTH)
                    slots_overwritten++;
                else
                    held_m++;
                history[newest_slot_m] = fresh;
                last_buttons_m = fresh.buttons;
            end
        end
        else if (it.read_limit != 0)
        begin
            take = (held_m < it.read_limit) ? held_m : it.read_limit;
            if (take == 0)
            begin
                // An empty ring answers with the held buttons alone.
                owed.rec = '0;
                owed.rec.buttons = last_buttons_m;
                owed.fallback = 1'b1;
                owed.last = 1'b1;
                records_due.push_back(owed);
            end
            else
            begin
                first = (newest_slot_m + DEPTH + 1 - held_m) % DEPTH;
                for (int i = 0; i < take; i++)
                begin
                    owed.rec = history[(first + i) % DEPTH];
                    owed.fallback = 1'b0;
                    owed.last = (i == take - 1);
                    records_due.push_back(owed);
                end
                held_m -= take;
                if (take > longest_read)
                    longest_read = take;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [47:0] want,
                                 input logic [47:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // Result checker and input-side predictor, both at the rising edge.
    always @(posedge clk)
    begin : monitor
        due_record_t  want;
        mouse_item_t  seen;
        if (!rst_n)
        begin
            took <= 1'b0;
        end
        else
        begin
            if (connected_we)
                link_up_m = connected_wdata;
            if (result_valid)
            begin
                if (records_due.size() == 0)
                begin
                    $error("result transfer with no record due: buttons %0h time %0h",
                           buttons, time_res);
                    fails++;
                end
                else
                begin
                    want = records_due.pop_front();
                    compare_field("buttons", want.rec.buttons, buttons);
                    compare_field("x_axis", want.rec.x_axis, x_axis);
                    compare_field("y_axis", want.rec.y_axis, y_axis);
                    compare_field("wheel", want.rec.wheel, wheel);
                    compare_field("tilt", want.rec.tilt, tilt);
                    compare_field("time_res", want.rec.time_res, time_res);
                    compare_field("from_last_state", want.fallback, from_last_state);
                    compare_field("is_last", want.last, is_last);
                    records_checked++;
                    if (want.fallback)
                        fallback_seen++;
                end
            end
            took <= start && !busy;
            if (start && !busy)
            begin
                seen.operation = mehr_pkg::op_t'(operation);
                seen.button_mask = button_mask;
                seen.pressed = pressed;
                seen.x_value = x_value;
                seen.y_value = y_value;
                seen.timestamp = timestamp;
                seen.read_limit = read_limit;
                apply_mouse_item(seen);
                items_taken++;
            end
        end
    end

    // Command driver: holds an item until its transfer, then picks the next one.
    always @(negedge clk)
    begin : sender
        mouse_item_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || took)
        begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                nxt = items_to_send.pop_front();
                operation <= nxt.operation;
                button_mask <= nxt.button_mask;
                pressed <= nxt.pressed;
                x_value <= nxt.x_value;
                y_value <= nxt.y_value;
                timestamp <= nxt.timestamp;
                read_limit <= nxt.read_limit;
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    function automatic mouse_item_t random_event();
        mouse_item_t it;
        it.operation = mehr_pkg::op_t'($urandom_range(2));
        it.button_mask = 8'($urandom);
        it.pressed = 1'($urandom);
        it.x_value = 16'($urandom);
        it.y_value = 16'($urandom);
        it.timestamp = {16'($urandom), $urandom};
        it.read_limit = mehr_pkg::LIMIT_W'($urandom_range(DEPTH));
        return it;
    endfunction

    function automatic mouse_item_t read_of(input int limit);
        mouse_item_t it;
        it = random_event();
        it.operation = mehr_pkg::OP_READ;
        it.read_limit = mehr_pkg::LIMIT_W'(limit);
        return it;
    endfunction

    function automatic mouse_item_t event_of(input mehr_pkg::op_t op,
                                             input logic [7:0] mask,
                                             input logic down, input logic [15:0] xv,
                                             input logic [15:0] yv,
                                             input logic [mehr_pkg::TIME_W-1:0] ts);
        mouse_item_t it;
        it = random_event();
        it.operation = op;
        it.button_mask = mask;
        it.pressed = down;
        it.x_value = xv;
        it.y_value = yv;
        it.timestamp = ts;
        return it;
    endfunction

    // Mostly event bursts followed by a read, with stray reads and events mixed in.
    task automatic queue_random_traffic(input int target);
        int added;
        int burst;
        int pick;
        int limit;
        added = 0;
        while (added < target)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                if ($urandom_range(9) == 0)
                    burst = $urandom_range(60, 80);
                else
                    burst = $urandom_range(0, 12);
                repeat (burst) items_to_send.push_back(random_event());
                case ($urandom_range(3))
                    0: limit = DEPTH;
                    1: limit = $urandom_range(1, 4);
                    default: limit = $urandom_range(1, DEPTH);
                endcase
                items_to_send.push_back(read_of(limit));
                added += burst + 1;
            end
            else if (pick < 88)
            begin
                items_to_send.push_back(read_of(0));
                added++;
            end
            else if (pick < 94)
            begin
                items_to_send.push_back(read_of($urandom_range(1, DEPTH)));
                added++;
            end
            else
            begin
                items_to_send.push_back(random_event());
                added++;
            end
        end
    endtask

    // Wait until every item has gone and every record due has arrived.
    task automatic settle();
        int waited;
        while (items_to_send.size() != 0 || start)
            @(posedge clk);
        waited = 0;
        while (records_due.size() != 0 && waited < QUIET_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (records_due.size() != 0)
        begin
            $error("%0d records never arrived", records_due.size());
            fails++;
            records_due.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_link(input logic up);
        @(negedge clk);
        connected_we <= 1'b1;
        connected_wdata <= up;
        @(negedge clk);
        connected_we <= 1'b0;
    endtask

    // Stimulus sequence: directed cases first, then random phases.
    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Disconnected: events are dropped, reads fall back to the last state.
        set_link(1'b0);
        items_to_send.push_back(read_of(0));
        items_to_send.push_back(read_of(1));
        items_to_send.push_back(event_of(mehr_pkg::OP_BUTTON, 8'hFF, 1'b1, 16'h0, 16'h0,
                                         48'h1));
        items_to_send.push_back(event_of(mehr_pkg::OP_MOVE, 8'h00, 1'b0, 16'h7FFF,
                                         16'h8000, 48'h2));
        items_to_send.push_back(read_of(3));
        settle();

        // Connected: field extremes, partial and over-long reads.
        set_link(1'b1);
        sender_idle_pct = 30;
        items_to_send.push_back(event_of(mehr_pkg::OP_BUTTON, 8'hFF, 1'b1, 16'h0, 16'h0,
                                         48'hFFFF_FFFF_FFFF));
        items_to_send.push_back(event_of(mehr_pkg::OP_BUTTON, 8'h0F, 1'b0, 16'hFFFF,
                                         16'hFFFF, 48'h0));
        items_to_send.push_back(event_of(mehr_pkg::OP_MOVE, 8'h00, 1'b0, 16'h8000,
                                         16'h7FFF, 48'h8000_0000_0001));
        items_to_send.push_back(event_of(mehr_pkg::OP_WHEEL, 8'hAA, 1'b1, 16'h7FFF,
                                         16'h8000, 48'h5555_5555_5555));
        items_to_send.push_back(event_of(mehr_pkg::OP_MOVE, 8'h55, 1'b1, 16'h5555,
                                         16'hAAAA, 48'hAAAA_AAAA_AAAA));
        items_to_send.push_back(read_of(2));
        items_to_send.push_back(read_of(0));
        items_to_send.push_back(read_of(DEPTH));
        items_to_send.push_back(read_of(1));
        repeat (3) items_to_send.push_back(random_event());
        settle();

        // Reads still drain the ring while the device is disconnected.
        set_link(1'b0);
        items_to_send.push_back(read_of(DEPTH));
        items_to_send.push_back(random_event());
        items_to_send.push_back(read_of(1));
        settle();

        // Random phases over both link settings and several sender rates.
        set_link(1'b1);
        sender_idle_pct = 0;
        queue_random_traffic(120);
        settle();

        set_link(1'b0);
        sender_idle_pct = 70;
        queue_random_traffic(50);
        settle();

        set_link(1'b1);
        queue_random_traffic(120);
        settle();

        sender_idle_pct = 13;
        queue_random_traffic(120);
        settle();

        $display("Ran %0d item transfers; checked %0d records (%0d last-state fallbacks).",
                 items_taken, records_checked, fallback_seen);
        $display("Ring slots overwritten when full: %0d; longest single read: %0d records.",
                 slots_overwritten, longest_read);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(WATCHDOG_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/mehr_pkg.sv
rtl/core/mehr_cell.sv
rtl/core/mehr_ctrl.sv
rtl/core/mouse_event_history_ring.sv
test/mouse_event_history_ring_tb.sv
